/* sv/psd_pkg.sv */
// Shared widths, sideband types and helpers for the point-to-segment distance pipeline.
`timescale 1ns / 1ps
package psd_pkg;

  localparam int CW  = 32;          // coordinate width, signed fixed point
  localparam int FB  = 16;          // fraction bits
  localparam int DW  = CW + 1;      // coordinate difference width
  localparam int PW  = 2 * DW;      // product of two differences
  localparam int LW  = PW + 1;      // squared length, unsigned
  localparam int OW  = LW + 1;      // dot product, signed
  localparam int AW  = FB + 1;      // projection ratio, 0 .. 2^FB
  localparam int PRW = DW + AW + 1; // difference times ratio
  localparam int RW  = CW + 2;      // square root width
  localparam int NW  = 2 * RW;      // radicand width, padded to whole digit pairs
  localparam int MW  = RW + 2;      // square root partial remainder
  localparam int GW  = CW + 1;      // distance output width

  // Sideband that travels with each item through the divider row
  typedef struct packed {
    logic          valid;
    logic          in_seg;
    logic          a_near;
    logic          q_top;
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    logic [CW-1:0] bx;
    logic [CW-1:0] by;
    logic [CW-1:0] qx;
    logic [CW-1:0] qy;
    logic [DW-1:0] dx;
    logic [DW-1:0] dy;
  } div_side_t;

  // Sideband that travels with each item through the square root row
  typedef struct packed {
    logic          valid;
    logic          in_seg;
    logic [CW-1:0] nx;
    logic [CW-1:0] ny;
  } sqrt_side_t;

  // Sign extend a coordinate by one bit
  function automatic logic signed [DW-1:0] ext(input logic [CW-1:0] v);
    return $signed({v[CW-1], v});
  endfunction

endpackage

/* sv/point_segment_distance.sv */
// Top level: closest point on a segment and distance to it, fully pipelined.
// Pipeline: an accepted item passes through 61 registers, the last of which drives done:
//   5 front stages, 16 divider cells, 5 projection stages, 34 square root cells, output.
// Throughput: one item per clock; busy is low whenever rst is low.
// Reset: rst clears every stage's valid bit; busy is high during reset.
// The receiver cannot stall: each result shows on the ports for one cycle.
`timescale 1ns / 1ps
module point_segment_distance import psd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [CW-1:0] seg_start_x,
  input  logic [CW-1:0] seg_start_y,
  input  logic [CW-1:0] seg_end_x,
  input  logic [CW-1:0] seg_end_y,
  input  logic [CW-1:0] query_x,
  input  logic [CW-1:0] query_y,
  output logic          done,
  output logic          inside_segment,
  output logic          on_segment,
  output logic [CW-1:0] nearest_x,
  output logic [CW-1:0] nearest_y,
  output logic [GW-1:0] gap
);

  logic accept;
  assign busy   = rst;
  assign accept = start && !busy;

  // front stage registers
  logic [CW-1:0] s1_ax, s1_ay, s1_bx, s1_by, s1_qx, s1_qy;
  logic [CW-1:0] s2_ax, s2_ay, s2_bx, s2_by, s2_qx, s2_qy;
  logic signed [DW-1:0] s2_dx, s2_dy, s2_pax, s2_pay, s2_pbx, s2_pby;
  logic [CW-1:0] s3_ax, s3_ay, s3_bx, s3_by, s3_qx, s3_qy;
  logic signed [DW-1:0] s3_dx, s3_dy;
  logic signed [PW-1:0] s3_ldx, s3_ldy, s3_tdx, s3_tdy, s3_ax2, s3_ay2, s3_bx2, s3_by2;
  logic [CW-1:0] s4_ax, s4_ay, s4_bx, s4_by, s4_qx, s4_qy;
  logic signed [DW-1:0] s4_dx, s4_dy;
  logic [LW-1:0] s4_len2, s4_da, s4_db;
  logic signed [OW-1:0] s4_dot;
  logic [4:0] fv;  // valid bits of front stages 1..5

  // divider row
  logic [LW-1:0] drem [0:FB];
  logic [LW-1:0] dden [0:FB];
  logic [FB-1:0] dquo [0:FB];
  div_side_t     dside [0:FB];

  // projection stages
  logic [CW-1:0] p1_ax, p1_ay, p1_bx, p1_by, p1_qx, p1_qy;
  logic signed [PRW-1:0] p1_offx, p1_offy;
  logic p1_inside, p1_a_near;
  logic [CW-1:0] p2_nx, p2_ny, p2_qx, p2_qy;
  logic p2_inside;
  logic [CW-1:0] p3_nx, p3_ny;
  logic signed [DW-1:0] p3_ex, p3_ey;
  logic p3_inside;
  logic [CW-1:0] p4_nx, p4_ny;
  logic signed [PW-1:0] p4_sqx, p4_sqy;
  logic p4_inside;
  logic [3:0] pv;  // valid bits of projection stages 1..4

  // square root row
  logic [NW-1:0] snum  [0:RW];
  logic [MW-1:0] srem  [0:RW];
  logic [RW-1:0] sroot [0:RW];
  sqrt_side_t    sside [0:RW];

  // stage 5 and projection combinational terms
  logic          c5_inside, c5_q_top;
  logic [AW-1:0] alpha;
  logic signed [PRW-1:0] rnd_x, rnd_y;
  localparam logic signed [PRW-1:0] RND = PRW'(1) << (FB - 1);

  assign c5_inside = (s4_len2 != '0) && !s4_dot[OW-1] && (s4_dot[LW-1:0] <= s4_len2);
  assign c5_q_top  = s4_dot[LW-1:0] == s4_len2;
  assign alpha     = {dside[FB].q_top, dquo[FB]};
  assign rnd_x     = p1_offx + RND;
  assign rnd_y     = p1_offy + RND;

  // front datapath: differences, products, sums
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ax <= seg_start_x; s1_ay <= seg_start_y;
      s1_bx <= seg_end_x;   s1_by <= seg_end_y;
      s1_qx <= query_x;     s1_qy <= query_y;
    end
    s2_ax <= s1_ax; s2_ay <= s1_ay; s2_bx <= s1_bx; s2_by <= s1_by;
    s2_qx <= s1_qx; s2_qy <= s1_qy;
    s2_dx  <= ext(s1_bx) - ext(s1_ax);
    s2_dy  <= ext(s1_by) - ext(s1_ay);
    s2_pax <= ext(s1_qx) - ext(s1_ax);
    s2_pay <= ext(s1_qy) - ext(s1_ay);
    s2_pbx <= ext(s1_qx) - ext(s1_bx);
    s2_pby <= ext(s1_qy) - ext(s1_by);

    s3_ax <= s2_ax; s3_ay <= s2_ay; s3_bx <= s2_bx; s3_by <= s2_by;
    s3_qx <= s2_qx; s3_qy <= s2_qy; s3_dx <= s2_dx; s3_dy <= s2_dy;
    s3_ldx <= s2_dx * s2_dx;
    s3_ldy <= s2_dy * s2_dy;
    s3_tdx <= s2_dx * s2_pax;
    s3_tdy <= s2_dy * s2_pay;
    s3_ax2 <= s2_pax * s2_pax;
    s3_ay2 <= s2_pay * s2_pay;
    s3_bx2 <= s2_pbx * s2_pbx;
    s3_by2 <= s2_pby * s2_pby;

    s4_ax <= s3_ax; s4_ay <= s3_ay; s4_bx <= s3_bx; s4_by <= s3_by;
    s4_qx <= s3_qx; s4_qy <= s3_qy; s4_dx <= s3_dx; s4_dy <= s3_dy;
    s4_len2 <= {1'b0, s3_ldx} + {1'b0, s3_ldy};
    s4_dot  <= $signed({{2{s3_tdx[PW-1]}}, s3_tdx}) + $signed({{2{s3_tdy[PW-1]}}, s3_tdy});
    s4_da   <= {1'b0, s3_ax2} + {1'b0, s3_ay2};
    s4_db   <= {1'b0, s3_bx2} + {1'b0, s3_by2};

    // stage 5: range test, nearer endpoint, top quotient bit, divider seed
    drem[0] <= c5_q_top ? '0 : s4_dot[LW-1:0];
    dden[0] <= s4_len2;
    dquo[0] <= '0;
    dside[0].valid  <= fv[3] && !rst;
    dside[0].in_seg <= c5_inside;
    dside[0].a_near <= s4_da <= s4_db;
    dside[0].q_top  <= c5_q_top;
    dside[0].ax <= s4_ax; dside[0].ay <= s4_ay;
    dside[0].bx <= s4_bx; dside[0].by <= s4_by;
    dside[0].qx <= s4_qx; dside[0].qy <= s4_qy;
    dside[0].dx <= s4_dx; dside[0].dy <= s4_dy;

    if (rst) begin
      fv <= '0;
    end else begin
      fv <= {fv[3:0], accept};
    end
  end

  // divider row, one quotient bit per cell
  for (genvar i = 0; i < FB; i++) begin : g_div
    psd_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .rem_in   (drem[i]),
      .den_in   (dden[i]),
      .quo_in   (dquo[i]),
      .side_in  (dside[i]),
      .rem_out  (drem[i+1]),
      .den_out  (dden[i+1]),
      .quo_out  (dquo[i+1]),
      .side_out (dside[i+1])
    );
  end

  // projection, nearest point, error vector and its square
  always_ff @(posedge clk) begin
    p1_ax <= dside[FB].ax; p1_ay <= dside[FB].ay;
    p1_bx <= dside[FB].bx; p1_by <= dside[FB].by;
    p1_qx <= dside[FB].qx; p1_qy <= dside[FB].qy;
    p1_inside <= dside[FB].in_seg;
    p1_a_near <= dside[FB].a_near;
    p1_offx <= $signed(dside[FB].dx) * $signed({1'b0, alpha});
    p1_offy <= $signed(dside[FB].dy) * $signed({1'b0, alpha});

    if (p1_inside) begin
      p2_nx <= p1_ax + rnd_x[FB+CW-1:FB];
      p2_ny <= p1_ay + rnd_y[FB+CW-1:FB];
    end else if (p1_a_near) begin
      p2_nx <= p1_ax;
      p2_ny <= p1_ay;
    end else begin
      p2_nx <= p1_bx;
      p2_ny <= p1_by;
    end
    p2_qx <= p1_qx; p2_qy <= p1_qy;
    p2_inside <= p1_inside;

    p3_nx <= p2_nx; p3_ny <= p2_ny;
    p3_ex <= ext(p2_qx) - ext(p2_nx);
    p3_ey <= ext(p2_qy) - ext(p2_ny);
    p3_inside <= p2_inside;

    p4_nx <= p3_nx; p4_ny <= p3_ny;
    p4_sqx <= p3_ex * p3_ex;
    p4_sqy <= p3_ey * p3_ey;
    p4_inside <= p3_inside;

    // squared distance seeds the root row
    snum[0]  <= {{(NW-LW){1'b0}}, ({1'b0, p4_sqx} + {1'b0, p4_sqy})};
    srem[0]  <= '0;
    sroot[0] <= '0;
    sside[0].valid  <= pv[3] && !rst;
    sside[0].in_seg <= p4_inside;
    sside[0].nx     <= p4_nx;
    sside[0].ny     <= p4_ny;

    if (rst) begin
      pv <= '0;
    end else begin
      pv <= {pv[2:0], dside[FB].valid};
    end
  end

  // square root row, one root bit per cell
  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    psd_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .num_in   (snum[j]),
      .rem_in   (srem[j]),
      .root_in  (sroot[j]),
      .side_in  (sside[j]),
      .num_out  (snum[j+1]),
      .rem_out  (srem[j+1]),
      .root_out (sroot[j+1]),
      .side_out (sside[j+1])
    );
  end

  // output register, distance saturates at all ones
  always_ff @(posedge clk) begin
    inside_segment <= sside[RW].in_seg;
    on_segment     <= sside[RW].in_seg && (sroot[RW] == '0);
    nearest_x      <= sside[RW].nx;
    nearest_y      <= sside[RW].ny;
    gap            <= sroot[RW][RW-1:GW] != '0 ? '1 : sroot[RW][GW-1:0];
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sside[RW].valid;
    end
  end

  // every accepted item comes out after the fixed latency, and nothing else does
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##61 done) else $error("item lost in pipeline");
  a_latency_bwd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 61)) else $error("result without an item");
  a_on_seg: assert property (@(posedge clk) disable iff (rst)
    done && on_segment |-> inside_segment && gap == '0)
    else $error("on_segment without zero distance");

endmodule

/* sv/psd_div_cell.sv */
// One restoring division step: a quotient bit per cell, registered toward the next cell.
`timescale 1ns / 1ps
module psd_div_cell import psd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [LW-1:0]    rem_in,
  input  logic [LW-1:0]    den_in,
  input  logic [FB-1:0]    quo_in,
  input  div_side_t        side_in,
  output logic [LW-1:0]    rem_out,
  output logic [LW-1:0]    den_out,
  output logic [FB-1:0]    quo_out,
  output div_side_t        side_out
);

  logic [LW:0] shifted;
  logic [LW:0] diff;
  logic        take;
  div_side_t   side_next;

  // shift remainder, trial subtract the divisor
  assign shifted = {rem_in, 1'b0};
  assign diff    = shifted - {1'b0, den_in};
  assign take    = shifted >= {1'b0, den_in};

  // sideband passes through, valid cleared in reset
  always_comb begin
    side_next       = side_in;
    side_next.valid = side_in.valid && !rst;
  end

  always_ff @(posedge clk) begin
    rem_out  <= take ? diff[LW-1:0] : shifted[LW-1:0];
    den_out  <= den_in;
    quo_out  <= {quo_in[FB-2:0], take};
    side_out <= side_next;
  end

endmodule

/* sv/psd_sqrt_cell.sv */
// One digit-by-digit square root step: a root bit per cell, registered toward the next cell.
`timescale 1ns / 1ps
module psd_sqrt_cell import psd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [NW-1:0]    num_in,
  input  logic [MW-1:0]    rem_in,
  input  logic [RW-1:0]    root_in,
  input  sqrt_side_t       side_in,
  output logic [NW-1:0]    num_out,
  output logic [MW-1:0]    rem_out,
  output logic [RW-1:0]    root_out,
  output sqrt_side_t       side_out
);

  logic [MW-1:0] cur;
  logic [MW-1:0] trial;
  logic          take;
  sqrt_side_t    side_next;

  // bring down the next two radicand bits, try root*4+1
  assign cur   = {rem_in[MW-3:0], num_in[NW-1:NW-2]};
  assign trial = {root_in, 2'b01};
  assign take  = cur >= trial;

  // sideband passes through, valid cleared in reset
  always_comb begin
    side_next       = side_in;
    side_next.valid = side_in.valid && !rst;
  end

  always_ff @(posedge clk) begin
    num_out  <= {num_in[NW-3:0], 2'b00};
    rem_out  <= take ? (cur - trial) : cur;
    root_out <= {root_in[RW-2:0], take};
    side_out <= side_next;
  end

endmodule

/* dv/tb_point_segment_distance.sv */
// Testbench for point_segment_distance: directed table plus random queries against a predictor.
`timescale 1ns / 1ps
module tb_point_segment_distance;
  import psd_pkg::*;

  localparam int ITEMS = 1400;
  localparam int DRAIN = 70;
  localparam logic [CW-1:0] ONE  = 32'h0001_0000;
  localparam logic [CW-1:0] HALF = 32'h0000_8000;
  localparam logic [CW-1:0] NEG1 = 32'hffff_0000;
  localparam logic [CW-1:0] TWO  = 32'h0002_0000;
  localparam logic [CW-1:0] MINC = 32'h8000_0000;
  localparam logic [CW-1:0] MAXC = 32'h7fff_ffff;

  typedef struct {
    logic [CW-1:0] ax, ay, bx, by, qx, qy;
  } query_t;

  typedef struct {
    logic          in_seg;
    logic          on_seg;
    logic [CW-1:0] nx, ny;
    logic [GW-1:0] gap_val;
  } answer_t;

  typedef struct {
    query_t  q;
    logic    typed;
    answer_t ans;
  } row_t;

  logic clk = 0, rst = 1, start = 0;
  logic busy, done, inside_segment, on_segment;
  logic [CW-1:0] seg_start_x = '0, seg_start_y = '0, seg_end_x = '0, seg_end_y = '0;
  logic [CW-1:0] query_x = '0, query_y = '0, nearest_x, nearest_y;
  logic [GW-1:0] gap;

  answer_t answers_due[$];
  row_t rows[$];
  int errors = 0, checked = 0, inside_seen = 0, on_seen = 0;

  point_segment_distance dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

  function automatic logic signed [127:0] widen(input logic [CW-1:0] v);
    return $signed({{(128-CW){v[CW-1]}}, v});
  endfunction

  // floor(sqrt(n)) by bitwise trial
  function automatic logic [127:0] root_floor(input logic [127:0] n);
    logic [127:0] r, t;
    r = '0;
    for (int i = 40; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // Closest point from a truncated ratio and rounded offset, and truncated distance
  function automatic answer_t nearest_point(input query_t q);
    logic signed [127:0] ax, ay, bx, by, px, py, dx, dy, len2, dot, alpha, off, da, db;
    logic signed [127:0] ex, ey, sq;
    logic [127:0] root;
    answer_t a;
    ax = widen(q.ax); ay = widen(q.ay); bx = widen(q.bx); by = widen(q.by);
    px = widen(q.qx); py = widen(q.qy);
    dx = bx - ax; dy = by - ay;
    len2 = dx * dx + dy * dy;
    dot = dx * (px - ax) + dy * (py - ay);
    a.in_seg = (len2 != 0) && (dot >= 0) && (dot <= len2);
    if (a.in_seg) begin
      alpha = (dot <<< FB) / len2;
      off = (dx * alpha + (128'sd1 <<< (FB - 1))) >>> FB;
      a.nx = CW'(ax + off);
      off = (dy * alpha + (128'sd1 <<< (FB - 1))) >>> FB;
      a.ny = CW'(ay + off);
    end else begin
      da = (px - ax) * (px - ax) + (py - ay) * (py - ay);
      db = (px - bx) * (px - bx) + (py - by) * (py - by);
      if (len2 == 0 || da <= db) begin
        a.nx = q.ax; a.ny = q.ay;
      end else begin
        a.nx = q.bx; a.ny = q.by;
      end
    end
    ex = px - widen(a.nx);
    ey = py - widen(a.ny);
    sq = ex * ex + ey * ey;
    root = root_floor(sq);
    a.gap_val = (root > {GW{1'b1}}) ? {GW{1'b1}} : GW'(root);
    a.on_seg = a.in_seg && (sq == 0);
    return a;
  endfunction

  function automatic logic [CW-1:0] pick_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return CW'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      2: begin
        case ($urandom_range(0, 4))
          0: return MINC;
          1: return MAXC;
          2: return '0;
          3: return ONE;
          default: return NEG1;
        endcase
      end
      default: return CW'($signed($urandom_range(0, 64)) - 32) << FB;
    endcase
  endfunction

  function automatic query_t random_query();
    query_t q;
    int mode;
    mode = $urandom_range(0, 3);
    q.ax = pick_coord(mode); q.ay = pick_coord(mode);
    q.bx = pick_coord(mode); q.by = pick_coord(mode);
    q.qx = pick_coord(mode); q.qy = pick_coord(mode);
    case ($urandom_range(0, 9))
      0: begin q.bx = q.ax; q.by = q.ay; end              // zero-length segment
      1: begin q.qx = q.ax; q.qy = q.ay; end              // query at an endpoint
      2: begin                                            // query at the midpoint
        q.ax[0] = 0; q.ay[0] = 0; q.bx[0] = 0; q.by[0] = 0;
        q.qx = CW'((widen(q.ax) + widen(q.bx)) >>> 1);
        q.qy = CW'((widen(q.ay) + widen(q.by)) >>> 1);
      end
      default: ;
    endcase
    return q;
  endfunction

  // Append one directed row to the stimulus table
  task automatic add_row(input query_t q, input logic typed, input answer_t ans);
    row_t r;
    r.q = q;
    r.typed = typed;
    r.ans = ans;
    rows = {rows, r};
  endtask

  // Burst/gap pacing for the sender
  int burst_left = 0;

  task automatic send_item(input query_t q, input logic typed, input answer_t ans);
    answer_t want;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    start <= 1'b1;
    seg_start_x <= q.ax; seg_start_y <= q.ay;
    seg_end_x <= q.bx; seg_end_y <= q.by;
    query_x <= q.qx; query_y <= q.qy;
    do @(posedge clk); while (busy);
    want = typed ? ans : nearest_point(q);
    answers_due = {answers_due, want};
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %0s: got %h expected %h at %0t", what, got, want, $time);
  endtask

  // Result check against the oldest outstanding answer
  always @(posedge clk) begin
    answer_t w;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        report("unexpected result", 64'(gap), 64'd0);
      end else begin
        w = answers_due.pop_front();
        checked++;
        inside_seen += inside_segment;
        on_seen += on_segment;
        if (inside_segment !== w.in_seg) report("inside_segment", 64'(inside_segment), 64'(w.in_seg));
        if (on_segment !== w.on_seg) report("on_segment", 64'(on_segment), 64'(w.on_seg));
        if (nearest_x !== w.nx) report("nearest_x", 64'(nearest_x), 64'(w.nx));
        if (nearest_y !== w.ny) report("nearest_y", 64'(nearest_y), 64'(w.ny));
        if (gap !== w.gap_val) report("gap", 64'(gap), 64'(w.gap_val));
      end
    end
  end

  initial begin
    query_t q;
    answer_t none;
    none = '{0, 0, '0, '0, '0};
    // Zero-length segment at the origin
    add_row('{0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0});
    // Zero-length segment, query one unit away
    add_row('{ONE, ONE, ONE, ONE, ONE, TWO}, 1, '{0, 0, ONE, ONE, GW'(ONE)});
    // Foot in the middle, one unit off the segment
    add_row('{0, 0, ONE, 0, HALF, ONE}, 1, '{1, 0, HALF, 0, GW'(ONE)});
    // Query on the segment
    add_row('{0, 0, TWO, 0, ONE, 0}, 1, '{1, 1, ONE, 0, 0});
    // Projection before A, and beyond B
    add_row('{0, 0, ONE, 0, NEG1, 0}, 1, '{0, 0, 0, 0, GW'(ONE)});
    add_row('{0, 0, ONE, 0, TWO, 0}, 1, '{0, 0, ONE, 0, GW'(ONE)});
    // Query exactly at A and at B
    add_row('{0, 0, ONE, ONE, 0, 0}, 1, '{1, 1, 0, 0, 0});
    add_row('{0, 0, ONE, ONE, ONE, ONE}, 1, '{1, 1, ONE, ONE, 0});
    // Extremes of the coordinate range, and small odd values near zero
    add_row('{MINC, MINC, MAXC, MAXC, MINC, MAXC}, 0, none);
    add_row('{MAXC, MINC, MINC, MAXC, MAXC, MAXC}, 0, none);
    add_row('{MINC, MINC, MINC, MINC, MAXC, MAXC}, 0, none);
    add_row('{MAXC, MAXC, MAXC, MAXC, MINC, MINC}, 0, none);
    add_row('{MINC, 0, MAXC, 0, 0, MAXC}, 0, none);
    add_row('{MINC, MINC, MAXC, MAXC, 0, 0}, 0, none);
    add_row('{MAXC, MAXC, MINC, MINC, MAXC, MINC}, 0, none);
    add_row('{32'h1, 32'h3, 32'hffff_fffd, 32'h7, 32'h5, 32'hffff_fff9}, 0, none);
    add_row('{32'hffff_ffff, 0, 32'h1, 0, 0, 32'h1}, 0, none);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    foreach (rows[i]) send_item(rows[i].q, rows[i].typed, rows[i].ans);

    for (int n = 0; n < ITEMS; n++) begin
      // Hold off once until the pipeline has drained
      if (n == ITEMS / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (answers_due.size() != 0) @(posedge clk);
        burst_left = 0;
      end
      q = random_query();
      send_item(q, 1'b0, none);
    end
    start <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("checked %0d results (%0d inside, %0d on segment) over directed and random queries",
             checked, inside_seen, on_seen);
    $display("%0d mismatches", errors);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
